>>> rtl/cbsm_pkg.sv
// Shared types and constants for the cartridge bank-switching mapper.
// Used by cbsm_front, cbsm_queue, cbsm_back and the top level.
package cbsm_pkg;

    // Bus access opcodes.
    localparam logic [2:0] OP_ROM_READ  = 3'd0;
    localparam logic [2:0] OP_CTRL_WRITE = 3'd1;
    localparam logic [2:0] OP_RAM_READ  = 3'd2;
    localparam logic [2:0] OP_RAM_WRITE = 3'd3;
    localparam logic [2:0] OP_ROM_LOAD  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_ROM_LIMIT = 1'b0;
    localparam logic CFG_RAM_LIMIT = 1'b1;

    // Field widths.
    localparam int OPCODE_W    = 3;
    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int LOAD_POS_W  = 19;
    localparam int ROM_LIMIT_W = 10;
    localparam int RAM_LIMIT_W = 5;
    localparam int CFG_DATA_W  = 10;
    localparam int ROM_SEL_W   = 5;
    localparam int RAM_SEL_W   = 2;
    localparam int ROM_OFF_W   = 14;
    localparam int RAM_OFF_W   = 13;

    // Physical address carried by a command: wide enough for the largest ROM.
    localparam int CMD_ADDR_W = 23;

    // Number of slots in the command queue.
    localparam int QUEUE_DEPTH = 2;

    // Control-write address windows and the start of the switched ROM window.
    localparam logic [ADDR_W-1:0] RAM_EN_END   = 16'h2000;
    localparam logic [ADDR_W-1:0] ROM_SEL_END  = 16'h4000;
    localparam logic [ADDR_W-1:0] RAM_SEL_END  = 16'h6000;
    localparam logic [ADDR_W-1:0] ROM_SWITCHED = 16'h4000;

    // RAM enable key.
    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    // Reset values.
    localparam logic [ROM_SEL_W-1:0]   ROM_SEL_RESET   = 5'd1;
    localparam logic [ROM_LIMIT_W-1:0] ROM_LIMIT_RESET = 10'd2;
    localparam logic [ROM_LIMIT_W-1:0] ROM_LIMIT_MIN   = 10'd2;

    // What the back end does with one command.
    typedef enum logic [2:0] {
        CMD_ZERO,
        CMD_ERROR,
        CMD_ROM_READ,
        CMD_ROM_WRITE,
        CMD_RAM_READ,
        CMD_RAM_WRITE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [CMD_ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]       data;
    } cmd_t;

endpackage

>>> rtl/cbsm_front.sv
// Front end: accepts bus accesses, applies control writes to the bank
// registers and turns each access into a physical memory command. Uses cbsm_pkg.
module cbsm_front #(
    parameter int ROM_BANKS = 32,
    parameter int RAM_BANKS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_index,
    input  logic [cbsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [cbsm_pkg::OPCODE_W-1:0]     opcode,
    input  logic [cbsm_pkg::ADDR_W-1:0]       bus_address,
    input  logic [cbsm_pkg::BYTE_W-1:0]       write_byte,
    input  logic [cbsm_pkg::LOAD_POS_W-1:0]   load_position,
    output logic                              push,
    output cbsm_pkg::cmd_t                    cmd
);
    import cbsm_pkg::*;

    localparam int ROM_BW = $clog2(ROM_BANKS);
    localparam int RAM_BW = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
    localparam int ROM_SEL_N = 1 << ROM_SEL_W;
    localparam int RAM_SEL_N = 1 << RAM_SEL_W;

    logic [ROM_LIMIT_W-1:0] rom_limit_reg;
    logic [RAM_LIMIT_W-1:0] ram_limit_reg;
    logic [ROM_SEL_W-1:0]   rom_sel_reg, rom_sel_next;
    logic [RAM_SEL_W-1:0]   ram_sel_reg, ram_sel_next;
    logic                   ram_en_reg, ram_en_next;

    logic [ROM_BW-1:0] rom_wrap [ROM_SEL_N];
    logic [RAM_BW-1:0] ram_wrap [RAM_SEL_N];

    logic [ROM_LIMIT_W-1:0] rom_lim_eff;
    logic [ROM_LIMIT_W-1:0] rom_cand;
    logic [RAM_LIMIT_W-1:0] ram_cand;
    logic                   ram_usable;

    // Bank numbers wrapped into the physical store, worked out at elaboration.
    for (genvar g = 0; g < ROM_SEL_N; g++) begin : g_rom_wrap
        assign rom_wrap[g] = ROM_BW'(g % ROM_BANKS);
    end
    for (genvar g = 0; g < RAM_SEL_N; g++) begin : g_ram_wrap
        assign ram_wrap[g] = RAM_BW'(g % RAM_BANKS);
    end

    assign push = in_valid && in_ready;
    assign ram_usable = ram_en_reg && (ram_limit_reg != '0);

    // Clamped bank candidates for a control write.
    always_comb
    begin
        rom_lim_eff = (rom_limit_reg < ROM_LIMIT_MIN) ? ROM_LIMIT_MIN : rom_limit_reg;
        rom_cand = ROM_LIMIT_W'(write_byte[ROM_SEL_W-1:0]);
        if (rom_cand == '0)
        begin
            rom_cand = ROM_LIMIT_W'(1);
        end
        if (rom_cand >= rom_lim_eff)
        begin
            rom_cand = rom_lim_eff - ROM_LIMIT_W'(1);
        end

        ram_cand = RAM_LIMIT_W'(write_byte[RAM_SEL_W-1:0]);
        if (ram_limit_reg == '0)
        begin
            ram_cand = '0;
        end
        else if (ram_cand >= ram_limit_reg)
        begin
            ram_cand = ram_limit_reg - RAM_LIMIT_W'(1);
        end
    end

    // Decode one access into a command and the next bank register values.
    always_comb
    begin
        rom_sel_next = rom_sel_reg;
        ram_sel_next = ram_sel_reg;
        ram_en_next  = ram_en_reg;
        cmd.kind = CMD_ZERO;
        cmd.addr = '0;
        cmd.data = write_byte;
        case (opcode)
            OP_ROM_READ:
            begin
                if (bus_address[ADDR_W-1])
                begin
                    cmd.kind = CMD_ERROR;
                end
                else if (bus_address < ROM_SWITCHED)
                begin
                    cmd.kind = CMD_ROM_READ;
                    cmd.addr = CMD_ADDR_W'(bus_address[ROM_OFF_W-1:0]);
                end
                else
                begin
                    cmd.kind = CMD_ROM_READ;
                    cmd.addr = CMD_ADDR_W'({rom_wrap[rom_sel_reg],
                                            bus_address[ROM_OFF_W-1:0]});
                end
            end
            OP_CTRL_WRITE:
            begin
                if (push)
                begin
                    if (bus_address < RAM_EN_END)
                    begin
                        ram_en_next = (write_byte[3:0] == RAM_EN_KEY);
                    end
                    else if (bus_address < ROM_SEL_END)
                    begin
                        rom_sel_next = rom_cand[ROM_SEL_W-1:0];
                    end
                    else if (bus_address < RAM_SEL_END)
                    begin
                        ram_sel_next = ram_cand[RAM_SEL_W-1:0];
                    end
                end
            end
            OP_RAM_READ:
            begin
                if (ram_usable)
                begin
                    cmd.kind = CMD_RAM_READ;
                    cmd.addr = CMD_ADDR_W'({ram_wrap[ram_sel_reg],
                                            bus_address[RAM_OFF_W-1:0]});
                end
            end
            OP_RAM_WRITE:
            begin
                if (ram_usable)
                begin
                    cmd.kind = CMD_RAM_WRITE;
                    cmd.addr = CMD_ADDR_W'({ram_wrap[ram_sel_reg],
                                            bus_address[RAM_OFF_W-1:0]});
                end
            end
            OP_ROM_LOAD:
            begin
                cmd.kind = CMD_ROM_WRITE;
                cmd.addr = CMD_ADDR_W'({rom_wrap[load_position[LOAD_POS_W-1:ROM_OFF_W]],
                                        load_position[ROM_OFF_W-1:0]});
            end
            default:
            begin
                cmd.kind = CMD_ZERO;
            end
        endcase
    end

    // Bank and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_limit_reg <= ROM_LIMIT_RESET;
            ram_limit_reg <= '0;
            rom_sel_reg   <= ROM_SEL_RESET;
            ram_sel_reg   <= '0;
            ram_en_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_ROM_LIMIT))
            begin
                rom_limit_reg <= cfg_data[ROM_LIMIT_W-1:0];
            end
            if (cfg_valid && (cfg_index == CFG_RAM_LIMIT))
            begin
                ram_limit_reg <= cfg_data[RAM_LIMIT_W-1:0];
            end
            rom_sel_reg <= rom_sel_next;
            ram_sel_reg <= ram_sel_next;
            ram_en_reg  <= ram_en_next;
        end
    end

endmodule

>>> rtl/cbsm_queue.sv
// Short command queue between the front end and the back end.
// Holds cbsm_pkg::cmd_t entries in order. Uses cbsm_pkg.
module cbsm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cbsm_pkg::cmd_t   push_cmd,
    output logic             not_full,
    output logic             not_empty,
    input  logic             pop,
    output cbsm_pkg::cmd_t   head_cmd
);
    import cbsm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/cbsm_back.sv
// Back end: carries out memory commands on the ROM and RAM stores and
// holds the result beat in an output register. Uses cbsm_pkg.
module cbsm_back #(
    parameter int ROM_BANKS = 32,
    parameter int RAM_BANKS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  cbsm_pkg::cmd_t                cmd,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cbsm_pkg::BYTE_W-1:0]   read_byte,
    output logic                          status
);
    import cbsm_pkg::*;

    localparam int ROM_DEPTH = ROM_BANKS * (1 << ROM_OFF_W);
    localparam int RAM_DEPTH = RAM_BANKS * (1 << RAM_OFF_W);
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    logic [BYTE_W-1:0] rom_mem [ROM_DEPTH];
    logic [BYTE_W-1:0] ram_mem [RAM_DEPTH];

    logic [BYTE_W-1:0] rom_q_reg;
    logic [BYTE_W-1:0] ram_q_reg;
    logic              mem_valid_reg;
    cmd_kind_t         mem_kind_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_status_reg;
    logic              advance;
    logic [ROM_AW-1:0] rom_addr;
    logic [RAM_AW-1:0] ram_addr;

    assign rom_addr = cmd.addr[ROM_AW-1:0];
    assign ram_addr = cmd.addr[RAM_AW-1:0];

    // The memory stage moves on when the output register is free or draining.
    assign advance = mem_valid_reg && (!out_valid_reg || out_ready);
    assign pop     = cmd_valid && (!mem_valid_reg || advance);

    assign out_valid = out_valid_reg;
    assign read_byte = out_byte_reg;
    assign status    = out_status_reg;

    // ROM store: one port, write for loads, registered read.
    always_ff @(posedge clk)
    begin
        if (pop && (cmd.kind == CMD_ROM_WRITE))
        begin
            rom_mem[rom_addr] <= cmd.data;
        end
        if (pop && (cmd.kind == CMD_ROM_READ))
        begin
            rom_q_reg <= rom_mem[rom_addr];
        end
    end

    // RAM store: one port, registered read.
    always_ff @(posedge clk)
    begin
        if (pop && (cmd.kind == CMD_RAM_WRITE))
        begin
            ram_mem[ram_addr] <= cmd.data;
        end
        if (pop && (cmd.kind == CMD_RAM_READ))
        begin
            ram_q_reg <= ram_mem[ram_addr];
        end
    end

    // Memory stage and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg  <= 1'b0;
            mem_kind_reg   <= CMD_ZERO;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_status_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mem_valid_reg <= 1'b1;
                mem_kind_reg  <= cmd.kind;
            end
            else if (advance)
            begin
                mem_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                case (mem_kind_reg)
                    CMD_ROM_READ:
                    begin
                        out_byte_reg   <= rom_q_reg;
                        out_status_reg <= 1'b0;
                    end
                    CMD_RAM_READ:
                    begin
                        out_byte_reg   <= ram_q_reg;
                        out_status_reg <= 1'b0;
                    end
                    CMD_ERROR:
                    begin
                        out_byte_reg   <= '0;
                        out_status_reg <= 1'b1;
                    end
                    default:
                    begin
                        out_byte_reg   <= '0;
                        out_status_reg <= 1'b0;
                    end
                endcase
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/cartridge_bank_switching_mapper.sv
// Cartridge bank-switching mapper: front end, command queue and back end.
// Depends on cbsm_pkg, cbsm_front, cbsm_queue and cbsm_back.
//
// Usage:
// - The input channel (in_valid/in_ready) takes one bus access per beat:
//   opcode, bus_address, write_byte and load_position.
// - The output channel (out_valid/out_ready) returns one result beat per
//   access, read_byte and status, in the order the accesses came in.
// - The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
//   writes the ROM bank limit (index 0) or the RAM bank limit (index 1).
//   It is always ready and is meant to be used while the block is idle.
// - An input beat goes through the queue, the memory stage and the output
//   register. The block takes one access per cycle unless the output stalls;
//   the single port of each store serves one access a cycle and sets the rate.
// - A two-entry command queue lets the front keep accepting while the back
//   waits on a stalled receiver; the output register holds the result until
//   it is taken, and in_ready drops once the queue fills.
// - Reset selects ROM bank 1 and RAM bank 0, disables RAM, and sets the
//   limits to two ROM banks and no RAM. Store contents are not cleared and
//   must be loaded before they are read.
module cartridge_bank_switching_mapper #(
    parameter int ROM_BANKS = 32,
    parameter int RAM_BANKS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [cbsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cbsm_pkg::OPCODE_W-1:0]     opcode,
    input  logic [cbsm_pkg::ADDR_W-1:0]       bus_address,
    input  logic [cbsm_pkg::BYTE_W-1:0]       write_byte,
    input  logic [cbsm_pkg::LOAD_POS_W-1:0]   load_position,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cbsm_pkg::BYTE_W-1:0]       read_byte,
    output logic                              status
);
    import cbsm_pkg::*;

    logic push;
    logic pop;
    logic q_not_full;
    logic q_not_empty;
    cmd_t front_cmd;
    cmd_t head_cmd;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_not_full;

    // Decode and bank register updates.
    cbsm_front #(
        .ROM_BANKS (ROM_BANKS),
        .RAM_BANKS (RAM_BANKS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .bus_address   (bus_address),
        .write_byte    (write_byte),
        .load_position (load_position),
        .push          (push),
        .cmd           (front_cmd)
    );

    // Commands waiting for the memory port.
    cbsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head_cmd  (head_cmd)
    );

    // Store access and result register.
    cbsm_back #(
        .ROM_BANKS (ROM_BANKS),
        .RAM_BANKS (RAM_BANKS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_byte (read_byte),
        .status    (status)
    );

endmodule
